### src/bitmap_segment_allocator_macros.svh
// assertion macros for the bitmap segment allocator
// users need signals named clk and rst_n in scope
`ifndef BITMAP_SEGMENT_ALLOCATOR_MACROS_SVH
`define BITMAP_SEGMENT_ALLOCATOR_MACROS_SVH

// same-cycle implication, off during reset
`define BSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bsa_pkg.sv
// shared constants, types and helper functions of the bitmap segment allocator
// no dependencies
`default_nettype none

package bsa_pkg;

  localparam int MEM_UNITS = 4096;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = MEM_UNITS / WORD_BITS;
  localparam int ADDR_W    = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int UNIT_W    = $clog2(MEM_UNITS);
  localparam int LEN_W     = UNIT_W + 1;
  localparam int RNG_W     = UNIT_W + 2;

  // fit modes, unused code behaves as first fit
  localparam logic [1:0] FIRST = 2'd0;
  localparam logic [1:0] BEST  = 2'd1;
  localparam logic [1:0] WORST = 2'd2;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // control from the sequencer to the hole scanner
  typedef struct packed {
    logic clear;
    logic step;
    logic bit_busy;
    logic flush;
  } scan_ctl_t;

  // bits of the word at wbase whose unit lies in [lo, hi)
  function automatic logic [WORD_BITS-1:0] range_mask(
    input logic [RNG_W-1:0] wbase,
    input logic [RNG_W-1:0] lo,
    input logic [RNG_W-1:0] hi
  );
    logic [WORD_BITS-1:0] m;
    logic [RNG_W-1:0]     u;
    for (int i = 0; i < WORD_BITS; i++) begin
      u    = wbase + RNG_W'(i);
      m[i] = (u >= lo) && (u < hi);
    end
    return m;
  endfunction

  // number of set bits in a word
  function automatic logic [BIT_W:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [BIT_W:0] c;
    c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c + (BIT_W+1)'(w[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### src/bsa_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/bsa_hole_scan.sv
// bit-serial hole tracker: follows free runs and keeps the chosen hole
// depends on bsa_pkg
`default_nettype none

module bsa_hole_scan (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bsa_pkg::scan_ctl_t        ctl,
  input  wire logic [bsa_pkg::UNIT_W-1:0] unit,
  input  wire logic [bsa_pkg::LEN_W-1:0]  len,
  input  wire logic [1:0]                mode,
  output logic                           found,
  output logic [bsa_pkg::UNIT_W-1:0]     base
);

  logic [bsa_pkg::LEN_W-1:0]  run_size_r;
  logic [bsa_pkg::UNIT_W-1:0] run_base_r;
  logic [bsa_pkg::LEN_W-1:0]  best_size_r;
  logic [bsa_pkg::UNIT_W-1:0] best_base_r;
  logic                       found_r;
  logic                       run_end;
  logic                       fits;
  logic                       take;

  // a run closes on a busy unit or at the end of the map
  assign run_end = (ctl.step && ctl.bit_busy) || ctl.flush;
  assign fits    = (run_size_r >= len) && (run_size_r != '0);

  // hole choice by fit mode, ties keep the lower address
  always_comb begin
    if (!found_r) begin
      take = 1'b1;
    end else if (mode == bsa_pkg::BEST) begin
      take = run_size_r < best_size_r;
    end else if (mode == bsa_pkg::WORST) begin
      take = run_size_r > best_size_r;
    end else begin
      take = 1'b0;
    end
  end

  // run tracking and best hole
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_size_r <= '0;
      found_r    <= 1'b0;
    end else if (ctl.clear) begin
      run_size_r <= '0;
      found_r    <= 1'b0;
    end else if (ctl.step && !ctl.bit_busy) begin
      if (run_size_r == '0) begin
        run_base_r <= unit;
      end
      run_size_r <= run_size_r + 1'b1;
    end else if (run_end) begin
      if (fits && take) begin
        found_r     <= 1'b1;
        best_base_r <= run_base_r;
        best_size_r <= run_size_r;
      end
      run_size_r <= '0;
    end
  end

  assign found = found_r;
  assign base  = best_base_r;

endmodule

`default_nettype wire

### src/bitmap_segment_allocator.sv
// Bitmap segment allocator. The occupancy map (one bit per unit, 128 words of 32)
// sits in a registered-read ram; words never written read as free, so there is no
// clearing pass after reset. start is taken when busy is low; one result word per
// request comes with out_valid high for exactly one cycle and cannot be held off.
// An allocate walks the whole map bit-serially, one unit per clock while a word
// is shifted out, with a read and a load state before each word; it then reads
// and writes each word it marks (none when no hole fits). A free reads and writes
// each word it touches; a zero length goes straight to the result. The bit-serial
// hole tracker and the ram address shared by reads and writes set this pacing.
// Depends on bsa_pkg, bsa_ram, bsa_hole_scan and bitmap_segment_allocator_macros.svh
`default_nettype none
`include "bitmap_segment_allocator_macros.svh"

module bitmap_segment_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_req_type,
  input  wire logic [bsa_pkg::LEN_W-1:0]  in_length,
  input  wire logic [bsa_pkg::UNIT_W-1:0] in_free_base,
  output logic                            out_valid,
  output logic                            out_status,
  output logic [bsa_pkg::UNIT_W-1:0]      out_granted_base,
  output logic [bsa_pkg::LEN_W-1:0]       out_free_units,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SC_RD, ST_SC_LD, ST_SC_BIT, ST_SC_END, ST_SC_CHK,
    ST_MK_RD, ST_MK_WR, ST_DONE
  } state_t;

  localparam int W  = bsa_pkg::WORD_BITS;
  localparam int RW = bsa_pkg::RNG_W;

  state_t                       state_r, state_nxt;
  logic [bsa_pkg::ADDR_W-1:0]   w_r, w_nxt;
  logic [bsa_pkg::BIT_W-1:0]    bit_r, bit_nxt;
  logic [W-1:0]                 sh_r, sh_nxt;
  logic                         req_r, req_nxt;
  logic [bsa_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [RW-1:0]                lo_r, lo_nxt;
  logic [RW-1:0]                hi_r, hi_nxt;
  logic [1:0]                   fit_mode_r, fit_mode_nxt;
  logic [bsa_pkg::LEN_W-1:0]    free_total_r, free_total_nxt;
  logic                         status_r, status_nxt;
  logic [bsa_pkg::UNIT_W-1:0]   grant_r, grant_nxt;
  logic [bsa_pkg::NUM_WORDS-1:0] vld_r, vld_nxt;
  logic                         vld_q_r, vld_q_nxt;

  logic                         ram_we;
  logic [W-1:0]                 ram_wdata;
  logic [W-1:0]                 ram_rdata;
  logic [W-1:0]                 eff_word;
  logic [W-1:0]                 mask;
  logic [RW-1:0]                wbase;
  logic [RW-1:0]                next_wbase;
  logic [RW-1:0]                free_sum;
  bsa_pkg::scan_ctl_t           scan_ctl;
  logic                         scan_found;
  logic [bsa_pkg::UNIT_W-1:0]   scan_base;

  // occupancy map storage
  bsa_ram #(
    .WIDTH (W),
    .DEPTH (bsa_pkg::NUM_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_r),
    .wdata (ram_wdata),
    .raddr (w_r),
    .rdata (ram_rdata)
  );

  // hole tracker
  bsa_hole_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .unit  ({w_r, bit_r}),
    .len   (len_r),
    .mode  (fit_mode_r),
    .found (scan_found),
    .base  (scan_base)
  );

  // unwritten words are free
  assign eff_word   = vld_q_r ? ram_rdata : '0;
  assign wbase      = RW'({w_r, {bsa_pkg::BIT_W{1'b0}}});
  assign next_wbase = wbase + RW'(W);
  assign mask       = bsa_pkg::range_mask(wbase, lo_r, hi_r);
  assign ram_wdata  = (req_r == bsa_pkg::REQ_FREE) ? (eff_word & ~mask) : (eff_word | mask);
  assign free_sum   = RW'(in_free_base) + RW'(in_length);
  assign vld_q_nxt  = vld_r[w_r];

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    bit_nxt        = bit_r;
    sh_nxt         = sh_r;
    req_nxt        = req_r;
    len_nxt        = len_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    fit_mode_nxt   = fit_mode_r;
    free_total_nxt = free_total_r;
    status_nxt     = status_r;
    grant_nxt      = grant_r;
    vld_nxt        = vld_r;
    ram_we         = 1'b0;
    scan_ctl       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          fit_mode_nxt = cfg_data;
        end
        if (start) begin
          req_nxt    = in_req_type;
          len_nxt    = in_length;
          status_nxt = 1'b0;
          grant_nxt  = '0;
          lo_nxt     = RW'(in_free_base);
          hi_nxt     = (free_sum > RW'(bsa_pkg::MEM_UNITS)) ? RW'(bsa_pkg::MEM_UNITS) : free_sum;
          bit_nxt    = '0;
          if (in_length == '0) begin
            state_nxt = ST_DONE;
          end else if (in_req_type == bsa_pkg::REQ_ALLOC) begin
            scan_ctl.clear = 1'b1;
            w_nxt          = '0;
            state_nxt      = ST_SC_RD;
          end else begin
            w_nxt     = in_free_base[bsa_pkg::UNIT_W-1:bsa_pkg::BIT_W];
            state_nxt = ST_MK_RD;
          end
        end
      end
      ST_SC_RD: begin
        state_nxt = ST_SC_LD;
      end
      ST_SC_LD: begin
        sh_nxt    = eff_word;
        bit_nxt   = '0;
        state_nxt = ST_SC_BIT;
      end
      ST_SC_BIT: begin
        scan_ctl.step     = 1'b1;
        scan_ctl.bit_busy = sh_r[0];
        sh_nxt            = sh_r >> 1;
        bit_nxt           = bit_r + 1'b1;
        if (bit_r == '1) begin
          if (w_r == '1) begin
            state_nxt = ST_SC_END;
          end else begin
            w_nxt     = w_r + 1'b1;
            state_nxt = ST_SC_RD;
          end
        end
      end
      ST_SC_END: begin
        scan_ctl.flush = 1'b1;
        state_nxt      = ST_SC_CHK;
      end
      ST_SC_CHK: begin
        if (scan_found) begin
          grant_nxt      = scan_base;
          lo_nxt         = RW'(scan_base);
          hi_nxt         = RW'(scan_base) + RW'(len_r);
          w_nxt          = scan_base[bsa_pkg::UNIT_W-1:bsa_pkg::BIT_W];
          free_total_nxt = free_total_r - len_r;
          state_nxt      = ST_MK_RD;
        end else begin
          status_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end
      end
      ST_MK_RD: begin
        state_nxt = ST_MK_WR;
      end
      ST_MK_WR: begin
        ram_we       = 1'b1;
        vld_nxt[w_r] = 1'b1;
        if (req_r == bsa_pkg::REQ_FREE) begin
          free_total_nxt = free_total_r
                         + bsa_pkg::LEN_W'(bsa_pkg::popcount(eff_word & mask));
        end
        if (next_wbase >= hi_r) begin
          state_nxt = ST_DONE;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = ST_MK_RD;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fit_mode_r   <= bsa_pkg::FIRST;
      free_total_r <= bsa_pkg::LEN_W'(bsa_pkg::MEM_UNITS);
      vld_r        <= '0;
      status_r     <= 1'b0;
      grant_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      fit_mode_r   <= fit_mode_nxt;
      free_total_r <= free_total_nxt;
      vld_r        <= vld_nxt;
      status_r     <= status_nxt;
      grant_r      <= grant_nxt;
    end
    w_r     <= w_nxt;
    bit_r   <= bit_nxt;
    sh_r    <= sh_nxt;
    req_r   <= req_nxt;
    len_r   <= len_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    vld_q_r <= vld_q_nxt;
  end

  // ports
  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = (state_r == ST_IDLE);
  assign out_valid        = (state_r == ST_DONE);
  assign out_status       = status_r;
  assign out_granted_base = grant_r;
  assign out_free_units   = free_total_r;

  // checks
  `BSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `BSA_ASSERT_IMPL(a_fail_no_base, out_valid && out_status, out_granted_base == '0, "failed allocate gave a base")
  `BSA_ASSERT_IMPL(a_total_range, out_valid, out_free_units <= bsa_pkg::LEN_W'(bsa_pkg::MEM_UNITS), "free total out of range")
  `BSA_ASSERT_IMPL(a_we_mark_only, ram_we, state_r == ST_MK_WR, "map written outside mark phase")

endmodule

`default_nettype wire
